@@ rtl/cbcr_pkg.sv @@
// shared types and constants for the circle against box collision resolver
package cbcr_pkg;

    localparam int unsigned GAIN_W     = 18;
    localparam int unsigned GAIN_FRAC  = 16;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 18'd117965;
    localparam int unsigned DIM_W      = 32;
    localparam int unsigned MAG_W      = 31;
    localparam int unsigned SQ_W       = 64;
    localparam int unsigned ROOT_W     = 32;

    // result fields carried to the output stage
    typedef struct packed {
        logic signed [DIM_W-1:0] x;
        logic signed [DIM_W-1:0] y;
        logic signed [DIM_W-1:0] vx;
        logic signed [DIM_W-1:0] vy;
        logic                    hit;
        logic                    bounced;
    } t_result;

    function automatic logic signed [DIM_W-1:0] sat32(input logic signed [95:0] v);
        logic signed [95:0] hi;
        logic signed [95:0] lo;
        hi = 96'sd2147483647;
        lo = -96'sd2147483648;
        if (v > hi) begin
            sat32 = 32'sh7fffffff;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[DIM_W-1:0];
        end
    endfunction

endpackage

@@ rtl/cbcr_pipe.sv @@
// stalling pipeline register slice used as the output register
module cbcr_pipe #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic             r_valid;
    logic [WIDTH-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/cbcr_sqrt.sv @@
// pipelined integer square root, one result bit per stage
module cbcr_sqrt (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [cbcr_pkg::SQ_W-1:0]       i_rad,
    output logic [cbcr_pkg::ROOT_W-1:0]     o_root
);

    localparam int unsigned N = cbcr_pkg::ROOT_W;

    logic [cbcr_pkg::SQ_W-1:0]   r_rem  [N];
    logic [cbcr_pkg::ROOT_W-1:0] r_root [N];
    logic [cbcr_pkg::SQ_W-1:0]   r_rad  [N];

    // stage s decides bit N-1-s of the root
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < N; s++) begin
                logic [cbcr_pkg::SQ_W-1:0]   rem_in;
                logic [cbcr_pkg::ROOT_W-1:0] root_in;
                logic [cbcr_pkg::SQ_W-1:0]   rad_in;
                logic [cbcr_pkg::SQ_W+1:0]   rem_sh;
                logic [cbcr_pkg::SQ_W+1:0]   trial;
                rem_in  = (s == 0) ? '0 : r_rem[s-1];
                root_in = (s == 0) ? '0 : r_root[s-1];
                rad_in  = (s == 0) ? i_rad : r_rad[s-1];
                rem_sh  = {rem_in, rad_in[cbcr_pkg::SQ_W-1 -: 2]};
                trial   = {root_in, 2'b01};
                if (rem_sh >= trial) begin
                    r_rem[s]  <= cbcr_pkg::SQ_W'(rem_sh - trial);
                    r_root[s] <= {root_in[N-2:0], 1'b1};
                end else begin
                    r_rem[s]  <= cbcr_pkg::SQ_W'(rem_sh);
                    r_root[s] <= {root_in[N-2:0], 1'b0};
                end
                r_rad[s] <= {rad_in[cbcr_pkg::SQ_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[N-1];

endmodule

@@ rtl/cbcr_div.sv @@
// pipelined restoring divider for the normal, one quotient bit per stage
module cbcr_div #(
    parameter int unsigned NUM_W = 48,
    parameter int unsigned DEN_W = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [DEN_W:0]   r_rem [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NUM_W; s++) begin
                logic [DEN_W:0]   rem_in;
                logic [NUM_W-1:0] num_in;
                logic [DEN_W-1:0] den_in;
                logic [DEN_W+1:0] sh;
                rem_in = (s == 0) ? '0 : r_rem[s-1];
                num_in = (s == 0) ? i_num : r_num[s-1];
                den_in = (s == 0) ? i_den : r_den[s-1];
                sh     = {rem_in, num_in[NUM_W-1]};
                if (sh >= {2'b00, den_in}) begin
                    r_rem[s] <= (DEN_W+1)'(sh - {2'b00, den_in});
                    r_num[s] <= {num_in[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[s] <= (DEN_W+1)'(sh);
                    r_num[s] <= {num_in[NUM_W-2:0], 1'b0};
                end
                r_den[s] <= den_in;
            end
        end
    end

    // the numerator register has been fully replaced by quotient bits
    assign o_quo = r_num[NUM_W-1];

endmodule

@@ rtl/circle_box_collision_resolve.sv @@
// top level: circle against axis-aligned box collision response pipeline
// throughput: one transfer per cycle unless stalled, set by the bit-per-stage root
// and divide pipes
// the whole pipe advances together and halts while a held result is stalled
// reset: synchronous active low, clears valid bits, gain returns to 1.8
module circle_box_collision_resolve #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [17:0]         i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_rect_left,
    input  logic signed [31:0]  i_rect_bottom,
    input  logic [30:0]         i_rect_width,
    input  logic [30:0]         i_rect_height,
    input  logic signed [31:0]  i_ball_x,
    input  logic signed [31:0]  i_ball_y,
    input  logic [30:0]         i_ball_radius,
    input  logic signed [31:0]  i_ball_vx,
    input  logic signed [31:0]  i_ball_vy,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_new_x,
    output logic signed [31:0]  o_new_y,
    output logic signed [31:0]  o_new_vx,
    output logic signed [31:0]  o_new_vy,
    output logic                o_hit,
    output logic                o_bounced
);

    localparam int unsigned NUM_W  = 31 + FRAC_BITS;
    localparam int unsigned SQ_LAT = cbcr_pkg::ROOT_W;
    localparam int unsigned DV_LAT = NUM_W;
    localparam int unsigned MID_LAT = SQ_LAT + DV_LAT;

    // carried alongside the root and divide pipes
    typedef struct packed {
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [30:0]        r;
        logic               dxn;
        logic               dyn;
        logic               hit;
        logic               live;
    } t_side;

    localparam int unsigned SIDE_W = $bits(t_side);

    logic [cbcr_pkg::GAIN_W-1:0] r_gain;
    logic en;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= cbcr_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    // stage 1: clamp and offsets
    logic signed [33:0] n_dx, n_dy;
    logic signed [33:0] right, top, cx, cy;
    always_comb begin
        right = 34'(i_rect_left) + 34'(signed'({1'b0, i_rect_width}));
        top   = 34'(i_rect_bottom) + 34'(signed'({1'b0, i_rect_height}));
        cx = 34'(i_ball_x);
        cy = 34'(i_ball_y);
        if (cx > right) cx = right;
        if (cx < 34'(i_rect_left)) cx = 34'(i_rect_left);
        if (cy > top) cy = top;
        if (cy < 34'(i_rect_bottom)) cy = 34'(i_rect_bottom);
        n_dx = 34'(i_ball_x) - cx;
        n_dy = 34'(i_ball_y) - cy;
    end

    logic               r1_v;
    logic signed [33:0] r1_dx, r1_dy;
    t_side              r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx <= n_dx;
            r1_dy <= n_dy;
            r1_side.bx  <= i_ball_x;
            r1_side.by  <= i_ball_y;
            r1_side.vx  <= i_ball_vx;
            r1_side.vy  <= i_ball_vy;
            r1_side.r   <= i_ball_radius;
            r1_side.dxn <= n_dx < 0;
            r1_side.dyn <= n_dy < 0;
            r1_side.hit <= 1'b0;
            r1_side.live <= 1'b0;
        end
    end

    // stage 2: magnitudes and squares
    logic [33:0] ax1, ay1;
    assign ax1 = r1_dx[33] ? 34'(-r1_dx) : 34'(r1_dx);
    assign ay1 = r1_dy[33] ? 34'(-r1_dy) : 34'(r1_dy);

    logic        r2_v;
    logic [30:0] r2_ax, r2_ay;
    logic        r2_far;
    logic [61:0] r2_ax2, r2_ay2, r2_r2;
    t_side       r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_far  <= (ax1[33:31] != 3'd0) || (ay1[33:31] != 3'd0);
            r2_ax   <= ax1[30:0];
            r2_ay   <= ay1[30:0];
            r2_ax2  <= ax1[30:0] * ax1[30:0];
            r2_ay2  <= ay1[30:0] * ay1[30:0];
            r2_r2   <= r1_side.r * r1_side.r;
            r2_side <= r1_side;
        end
    end

    // stage 3: distance squared and contact test
    logic [62:0] d2;
    assign d2 = 63'(r2_ax2) + 63'(r2_ay2);

    logic        r3_v;
    logic [62:0] r3_d2;
    logic [30:0] r3_ax, r3_ay;
    t_side       r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_d2 <= d2;
            r3_ax <= r2_ax;
            r3_ay <= r2_ay;
            r3_side.bx   <= r2_side.bx;
            r3_side.by   <= r2_side.by;
            r3_side.vx   <= r2_side.vx;
            r3_side.vy   <= r2_side.vy;
            r3_side.r    <= r2_side.r;
            r3_side.dxn  <= r2_side.dxn;
            r3_side.dyn  <= r2_side.dyn;
            r3_side.hit  <= !r2_far && (63'(r2_r2) > d2);
            r3_side.live <= !r2_far && (63'(r2_r2) > d2) && (d2 != 63'd0);
        end
    end

    // root of d2
    logic [31:0] root;
    cbcr_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  ({1'b0, r3_d2}),
        .o_root (root)
    );

    logic            sq_v;
    logic [SIDE_W+61:0] sq_d;

    // delay line for side data beside the root pipe
    logic [SIDE_W+61:0] r_sq_dly [SQ_LAT];
    logic               r_sq_v   [SQ_LAT];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SQ_LAT; i++) r_sq_v[i] <= 1'b0;
        end else if (en) begin
            r_sq_v[0] <= r3_v;
            for (int i = 1; i < SQ_LAT; i++) r_sq_v[i] <= r_sq_v[i-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_dly[0] <= {r3_side, r3_ax, r3_ay};
            for (int i = 1; i < SQ_LAT; i++) r_sq_dly[i] <= r_sq_dly[i-1];
        end
    end
    assign sq_v = r_sq_v[SQ_LAT-1];
    assign sq_d = r_sq_dly[SQ_LAT-1];

    t_side       s4_side;
    logic [30:0] s4_ax, s4_ay;
    logic [31:0] den;
    assign {s4_side, s4_ax, s4_ay} = sq_d;
    assign den = (root == 32'd0) ? 32'd1 : root;

    logic [NUM_W-1:0] qx, qy;
    cbcr_div #(.NUM_W(NUM_W), .DEN_W(32)) u_div_x (
        .i_clk (i_clk), .i_en (en),
        .i_num ({s4_ax, {FRAC_BITS{1'b0}}}), .i_den (den), .o_quo (qx)
    );
    cbcr_div #(.NUM_W(NUM_W), .DEN_W(32)) u_div_y (
        .i_clk (i_clk), .i_en (en),
        .i_num ({s4_ay, {FRAC_BITS{1'b0}}}), .i_den (den), .o_quo (qy)
    );

    // side data and overlap beside the divide pipe
    logic [SIDE_W+31:0] r_dv_dly [DV_LAT];
    logic               r_dv_v   [DV_LAT];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DV_LAT; i++) r_dv_v[i] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= sq_v;
            for (int i = 1; i < DV_LAT; i++) r_dv_v[i] <= r_dv_v[i-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_dly[0] <= {s4_side, 32'({1'b0, s4_side.r}) - root};
            for (int i = 1; i < DV_LAT; i++) r_dv_dly[i] <= r_dv_dly[i-1];
        end
    end

    t_side       s5_side;
    logic [31:0] s5_ov;
    logic        s5_v;
    assign {s5_side, s5_ov} = r_dv_dly[DV_LAT-1];
    assign s5_v = r_dv_v[DV_LAT-1];

    // stage 6: products with the normal (magnitudes, normal at most 2^FRAC_BITS)
    logic        r6_v;
    t_side       r6_side;
    logic [NUM_W-1:0] r6_nx, r6_ny;
    logic [63:0] r6_px, r6_py;
    logic signed [64+FRAC_BITS:0] r6_vnx, r6_vny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_side <= s5_side;
            r6_nx   <= qx;
            r6_ny   <= qy;
            r6_px   <= 64'(s5_ov) * 64'(qx[FRAC_BITS:0]);
            r6_py   <= 64'(s5_ov) * 64'(qy[FRAC_BITS:0]);
            r6_vnx  <= (65+FRAC_BITS)'(s5_side.vx) *
                       (s5_side.dxn ? -(65+FRAC_BITS)'(signed'({1'b0, qx[FRAC_BITS:0]}))
                                    : (65+FRAC_BITS)'(signed'({1'b0, qx[FRAC_BITS:0]})));
            r6_vny  <= (65+FRAC_BITS)'(s5_side.vy) *
                       (s5_side.dyn ? -(65+FRAC_BITS)'(signed'({1'b0, qy[FRAC_BITS:0]}))
                                    : (65+FRAC_BITS)'(signed'({1'b0, qy[FRAC_BITS:0]})));
        end
    end

    // stage 7: new position and dot
    logic signed [65+FRAC_BITS:0] dsum;
    logic [65+FRAC_BITS:0]        dmag;
    logic signed [65+FRAC_BITS:0] dot_full;
    logic signed [47:0]           pxs, pys;
    always_comb begin
        dsum = (66+FRAC_BITS)'(r6_vnx) + (66+FRAC_BITS)'(r6_vny);
        dmag = dsum[65+FRAC_BITS] ? (66+FRAC_BITS)'(-dsum) : (66+FRAC_BITS)'(dsum);
        dot_full = dsum[65+FRAC_BITS] ? -(signed'(dmag >> FRAC_BITS))
                                      : signed'(dmag >> FRAC_BITS);
        pxs = r6_side.dxn ? -48'(r6_px >> FRAC_BITS) : 48'(r6_px >> FRAC_BITS);
        pys = r6_side.dyn ? -48'(r6_py >> FRAC_BITS) : 48'(r6_py >> FRAC_BITS);
    end

    logic        r7_v;
    t_side       r7_side;
    logic [NUM_W-1:0] r7_nx, r7_ny;
    logic signed [47:0] r7_x, r7_y;
    logic        r7_neg;
    logic [32:0] r7_dmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_side <= r6_side;
            r7_nx   <= r6_nx;
            r7_ny   <= r6_ny;
            r7_x    <= 48'(r6_side.bx) + pxs;
            r7_y    <= 48'(r6_side.by) + pys;
            r7_neg  <= dot_full < 0;
            r7_dmag <= 33'(dot_full < 0 ? -dot_full : dot_full);
        end
    end

    // stage 8: k magnitude = gain * |dot| >> 16
    logic        r8_v;
    t_side       r8_side;
    logic [NUM_W-1:0] r8_nx, r8_ny;
    logic signed [47:0] r8_x, r8_y;
    logic        r8_neg;
    logic [33:0] r8_km;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en) begin
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_side <= r7_side;
            r8_nx   <= r7_nx;
            r8_ny   <= r7_ny;
            r8_x    <= r7_x;
            r8_y    <= r7_y;
            r8_neg  <= r7_neg;
            r8_km   <= 34'((51'(r_gain) * 51'(r7_dmag)) >> cbcr_pkg::GAIN_FRAC);
        end
    end

    // stage 9: velocity change magnitudes
    logic        r9_v;
    t_side       r9_side;
    logic signed [47:0] r9_x, r9_y;
    logic        r9_neg;
    logic [95:0] r9_cx, r9_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (en) begin
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_side <= r8_side;
            r9_x    <= r8_x;
            r9_y    <= r8_y;
            r9_neg  <= r8_neg;
            r9_cx   <= (96'(r8_km) * 96'(r8_nx[FRAC_BITS:0])) >> FRAC_BITS;
            r9_cy   <= (96'(r8_km) * 96'(r8_ny[FRAC_BITS:0])) >> FRAC_BITS;
        end
    end

    // stage 10: apply, saturate, output register
    // k is positive here (dot is negative), so the change follows the sign of the normal
    cbcr_pkg::t_result n_res;
    always_comb begin
        logic signed [95:0] cxs, cys;
        logic bounce;
        cxs = r9_side.dxn ? -signed'(r9_cx) : signed'(r9_cx);
        cys = r9_side.dyn ? -signed'(r9_cy) : signed'(r9_cy);
        bounce = r9_side.live && r9_neg;
        n_res.hit     = r9_side.hit;
        n_res.bounced = bounce;
        n_res.x  = r9_side.live ? cbcr_pkg::sat32(96'(r9_x)) : r9_side.bx;
        n_res.y  = r9_side.live ? cbcr_pkg::sat32(96'(r9_y)) : r9_side.by;
        n_res.vx = bounce ? cbcr_pkg::sat32(96'(r9_side.vx) + cxs) : r9_side.vx;
        n_res.vy = bounce ? cbcr_pkg::sat32(96'(r9_side.vy) + cys) : r9_side.vy;
    end

    logic [$bits(cbcr_pkg::t_result)-1:0] res_q;
    cbcr_pkg::t_result res;
    cbcr_pipe #(.WIDTH($bits(cbcr_pkg::t_result))) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r9_v),
        .i_data  (n_res),
        .o_valid (o_valid),
        .o_data  (res_q)
    );
    assign res = res_q;

    assign o_new_x   = res.x;
    assign o_new_y   = res.y;
    assign o_new_vx  = res.vx;
    assign o_new_vy  = res.vy;
    assign o_hit     = res.hit;
    assign o_bounced = res.bounced;

endmodule
